FILE: design/hsr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hsr_pkg: shared types and constants of the Heron square root
// Field widths, configuration register indexes and the command and status
// bundles between the sequencer and the datapath.
// ----------------------------------------------------------------------------
package hsr_pkg;

  // Port field widths
  localparam int RADICAND_WIDTH  = 32;
  localparam int ROOT_WIDTH      = 32;
  localparam int STEPS_WIDTH     = 8;
  localparam int TOLERANCE_WIDTH = 32;
  localparam int CFG_INDEX_WIDTH = 1;
  localparam int CFG_DATA_WIDTH  = 32;

  typedef logic [CFG_INDEX_WIDTH-1:0] cfg_index_t;
  typedef logic [STEPS_WIDTH-1:0]     steps_t;
  typedef logic [TOLERANCE_WIDTH-1:0] tolerance_t;

  // Configuration register indexes
  localparam cfg_index_t REG_TOLERANCE       = 1'b0;
  localparam cfg_index_t REG_ITERATION_LIMIT = 1'b1;

  // Reset values of the configuration registers
  localparam tolerance_t TOLERANCE_RESET       = 32'd7;
  localparam steps_t     ITERATION_LIMIT_RESET = 8'd32;

  // Sequencer to datapath commands
  typedef struct packed {
    logic load;       // take a new radicand, set guess to the start value
    logic div_start;  // launch z / x on the divider
    logic capture;    // register the halved sum of guess and quotient
    logic update;     // move the new guess into the guess register
    logic out_load;   // copy the guess into the output register
  } hsr_cmd_t;

  // Datapath to sequencer status
  typedef struct packed {
    logic div_done;   // quotient valid this cycle
    logic nx_zero;    // new guess is zero
    logic in_tol;     // change of guess below tolerance
  } hsr_status_t;

endpackage
`default_nettype wire

FILE: design/heron_square_root.sv
`timescale 1ns / 1ps
`default_nettype none
// Heron square root: one unsigned fixed-point radicand in, one root out,
// with the number of Newton steps and a converged flag. Each Newton step
// runs one bit-serial division on a shared radix-2 divider, and the block
// takes no new radicand until the current one is finished. A finished
// result waits in an output register, so the next radicand is taken while
// it is still pending. Configuration writes must only be issued while the
// block is idle.
// ----------------------------------------------------------------------------
// heron_square_root: fixed-point Newton square root
// Top level: configuration registers, sequencer and datapath.
// ----------------------------------------------------------------------------
module heron_square_root
  import hsr_pkg::*;
#(
  parameter int FRACTION_BITS = 16,
  parameter int DATA_WIDTH    = 32
) (
  input  wire                       clk,
  input  wire                       rst,
  input  wire                       cfg_valid,
  output logic                      cfg_ready,
  input  wire [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  wire [CFG_DATA_WIDTH-1:0]  cfg_data,
  input  wire                       in_valid,
  output logic                      in_ready,
  input  wire [RADICAND_WIDTH-1:0]  radicand,
  output logic                      out_valid,
  input  wire                       out_ready,
  output logic [ROOT_WIDTH-1:0]     root,
  output logic [STEPS_WIDTH-1:0]    steps_taken,
  output logic                      converged
);

  tolerance_t  tolerance;
  steps_t      iteration_limit;
  hsr_cmd_t    cmd;
  hsr_status_t status;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance       <= TOLERANCE_RESET;
      iteration_limit <= ITERATION_LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_TOLERANCE:       tolerance       <= cfg_data[TOLERANCE_WIDTH-1:0];
        REG_ITERATION_LIMIT: iteration_limit <= cfg_data[STEPS_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  hsr_control u_control (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .iteration_limit (iteration_limit),
    .status          (status),
    .cmd             (cmd),
    .steps_taken     (steps_taken),
    .converged       (converged)
  );

  hsr_datapath #(
    .FRACTION_BITS (FRACTION_BITS),
    .DATA_WIDTH    (DATA_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .radicand  (radicand),
    .tolerance (tolerance),
    .root      (root)
  );

endmodule
`default_nettype wire

FILE: design/hsr_divider.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hsr_divider: radix-2 restoring fixed-point divider
// Computes (dividend << FRACTION_BITS) / divisor one quotient bit per cycle,
// saturating the quotient to all ones. The divisor must be nonzero.
// ----------------------------------------------------------------------------
module hsr_divider
  import hsr_pkg::*;
#(
  parameter int FRACTION_BITS = 16,
  parameter int DATA_WIDTH    = 32
) (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   start,
  input  wire [DATA_WIDTH-1:0]  dividend,
  input  wire [DATA_WIDTH-1:0]  divisor,
  output logic                  done,
  output logic [DATA_WIDTH-1:0] quotient
);

  localparam int ITER  = DATA_WIDTH + FRACTION_BITS;
  localparam int CNT_W = $clog2(ITER + 1);

  logic                  busy;
  logic [CNT_W-1:0]      count;
  logic [ITER-1:0]       num;
  logic [DATA_WIDTH-1:0] rem;
  logic [DATA_WIDTH-1:0] dsr;
  logic [DATA_WIDTH-1:0] quo;
  logic                  sat;

  logic [DATA_WIDTH:0]   rem_shift;
  logic [DATA_WIDTH+1:0] trial;
  logic                  fits;

  // Trial subtract of the divisor from the shifted partial remainder
  always_comb begin
    rem_shift = {rem, num[ITER-1]};
    trial     = {1'b0, rem_shift} - {2'b00, dsr};
    fits      = ~trial[DATA_WIDTH+1];
  end

  // Control: busy flag, bit counter, done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy  <= 1'b1;
        count <= CNT_W'(ITER);
      end else if (busy) begin
        count <= count - CNT_W'(1);
        if (count == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: shift in dividend bits, restore or keep remainder
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      num <= {dividend, {FRACTION_BITS{1'b0}}};
      dsr <= divisor;
      rem <= '0;
      quo <= '0;
      sat <= 1'b0;
    end else if (busy) begin
      num <= {num[ITER-2:0], 1'b0};
      rem <= fits ? trial[DATA_WIDTH-1:0] : rem_shift[DATA_WIDTH-1:0];
      quo <= {quo[DATA_WIDTH-2:0], fits};
      // a one shifted out of the top means the quotient overflowed
      sat <= sat | quo[DATA_WIDTH-1];
    end
  end

  assign quotient = sat ? {DATA_WIDTH{1'b1}} : quo;

endmodule
`default_nettype wire

FILE: design/hsr_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hsr_datapath: guess, radicand and result registers of the Heron root
// Holds the radicand and guess, runs the divider, forms the halved sum,
// measures the change against the tolerance and drives the root output.
// ----------------------------------------------------------------------------
module hsr_datapath
  import hsr_pkg::*;
#(
  parameter int FRACTION_BITS = 16,
  parameter int DATA_WIDTH    = 32
) (
  input  wire                       clk,
  input  wire                       rst,
  input  hsr_cmd_t                  cmd,
  output hsr_status_t               status,
  input  wire [RADICAND_WIDTH-1:0]  radicand,
  input  wire [TOLERANCE_WIDTH-1:0] tolerance,
  output logic [ROOT_WIDTH-1:0]     root
);

  localparam int WIDE = (DATA_WIDTH > 32) ? DATA_WIDTH : 32;
  localparam logic [DATA_WIDTH-1:0] START_X =
    (FRACTION_BITS + 2 > DATA_WIDTH) ? {DATA_WIDTH{1'b1}} :
    ({{(DATA_WIDTH-1){1'b0}}, 1'b1} << (FRACTION_BITS + 1));
  localparam logic [WIDE-1:0] DW_MAX  = WIDE'({DATA_WIDTH{1'b1}});
  localparam logic [WIDE-1:0] OUT_MAX = WIDE'({ROOT_WIDTH{1'b1}});

  logic [DATA_WIDTH-1:0] z;
  logic [DATA_WIDTH-1:0] x;
  logic [DATA_WIDTH-1:0] nx;
  logic [DATA_WIDTH-1:0] quotient;
  logic                  div_done;

  logic [WIDE-1:0]       rad_wide;
  logic [DATA_WIDTH-1:0] z_load;
  logic [DATA_WIDTH:0]   sum;
  logic [DATA_WIDTH:0]   rise;
  logic [DATA_WIDTH-1:0] fall;
  logic [DATA_WIDTH-1:0] change;
  logic [WIDE-1:0]       x_wide;

  hsr_divider #(
    .FRACTION_BITS (FRACTION_BITS),
    .DATA_WIDTH    (DATA_WIDTH)
  ) u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (z),
    .divisor  (x),
    .done     (div_done),
    .quotient (quotient)
  );

  // Saturate the radicand into the working width
  always_comb begin
    rad_wide = WIDE'(radicand);
    z_load   = (rad_wide > DW_MAX) ? {DATA_WIDTH{1'b1}} : rad_wide[DATA_WIDTH-1:0];
  end

  // Halved sum of guess and quotient, one bit wider before the shift
  assign sum = {1'b0, x} + {1'b0, quotient};

  // Absolute change between the new and the current guess
  always_comb begin
    rise   = {1'b0, nx} - {1'b0, x};
    fall   = x - nx;
    change = rise[DATA_WIDTH] ? fall : rise[DATA_WIDTH-1:0];
  end

  always_comb begin
    status.div_done = div_done;
    status.nx_zero  = (nx == '0);
    status.in_tol   = WIDE'(change) < WIDE'(tolerance);
  end

  // Guess and radicand registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      z <= z_load;
      x <= START_X;
    end else if (cmd.update) begin
      x <= nx;
    end
    if (cmd.capture) begin
      nx <= sum[DATA_WIDTH:1];
    end
  end

  // Output register, guess saturated to the port width
  assign x_wide = WIDE'(x);

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      root <= (x_wide > OUT_MAX) ? {ROOT_WIDTH{1'b1}} : x_wide[ROOT_WIDTH-1:0];
    end
  end

endmodule
`default_nettype wire

FILE: design/hsr_control.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hsr_control: sequencer of the Heron root
// Accepts radicands, steps the datapath through divide, capture and update,
// counts Newton steps against the limit and drives the result handshake.
// ----------------------------------------------------------------------------
module hsr_control
  import hsr_pkg::*;
(
  input  wire              clk,
  input  wire              rst,
  input  wire              in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  wire              out_ready,
  input  wire  [STEPS_WIDTH-1:0] iteration_limit,
  input  hsr_status_t      status,
  output hsr_cmd_t         cmd,
  output logic [STEPS_WIDTH-1:0] steps_taken,
  output logic             converged
);

  typedef enum logic [4:0] {
    IDLE   = 5'b00001,
    LAUNCH = 5'b00010,
    DIVIDE = 5'b00100,
    CHECK  = 5'b01000,
    FINISH = 5'b10000
  } state_t;

  state_t state, state_next;
  steps_t steps;
  steps_t steps_inc;
  logic   conv;
  logic   out_free;

  assign steps_inc = steps + steps_t'(1);
  assign out_free  = !out_valid || out_ready;
  assign in_ready  = (state == IDLE);

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = (iteration_limit == '0) ? FINISH : LAUNCH;
        end
      end
      LAUNCH: begin
        cmd.div_start = 1'b1;
        state_next    = DIVIDE;
      end
      DIVIDE: begin
        if (status.div_done) begin
          cmd.capture = 1'b1;
          state_next  = CHECK;
        end
      end
      CHECK: begin
        cmd.update = 1'b1;
        if (status.nx_zero || status.in_tol || steps_inc == iteration_limit) begin
          state_next = FINISH;
        end else begin
          state_next = LAUNCH;
        end
      end
      FINISH: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = IDLE;
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  // State, step counter and convergence flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      steps <= '0;
      conv  <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load) begin
        steps <= '0;
        conv  <= 1'b0;
      end else if (cmd.update) begin
        steps <= steps_inc;
        conv  <= status.nx_zero || status.in_tol;
      end
    end
  end

  // Result beat: hold until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      steps_taken <= steps;
      converged   <= conv;
    end
  end

endmodule
`default_nettype wire

FILE: design/hsr_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hsr_checker: port-level checks of the Heron square root
// Watches the top-level ports and flags sequencing and result slips.
// ----------------------------------------------------------------------------
module hsr_checker
  import hsr_pkg::*;
(
  input wire                       clk,
  input wire                       rst,
  input wire                       in_valid,
  input wire                       in_ready,
  input wire                       out_valid,
  input wire                       out_ready,
  input wire [ROOT_WIDTH-1:0]      root,
  input wire [STEPS_WIDTH-1:0]     steps_taken,
  input wire                       converged
);

  // Reset leaves no result beat pending
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result beat pending after reset");

  // An accepted radicand keeps the block busy for the next cycle
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again right after a radicand beat");

  // Convergence needs at least one Newton step
  assert property (@(posedge clk) disable iff (rst)
    out_valid && converged |-> steps_taken != '0)
    else $error("converged result with zero steps");

  // A stalled result beat holds its payload
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=>
      out_valid && $stable(root) && $stable(steps_taken) && $stable(converged))
    else $error("result beat changed while stalled");

endmodule

bind heron_square_root hsr_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .root        (root),
  .steps_taken (steps_taken),
  .converged   (converged)
);
`default_nettype wire
